### src/hsvrgb_pkg.sv
// Shared types and constants for the HSV to RGB converter pipeline.
package hsvrgb_pkg;

	localparam int unsigned PIPE_DEPTH  = 10;
	localparam int unsigned HUE_FULL    = 360;
	localparam int unsigned SECTOR_SPAN = 60;
	localparam int unsigned UNIT_MAX    = 255;
	localparam int unsigned LEVEL_DENOM = UNIT_MAX * SECTOR_SPAN;

	// floor(mag / 360) == (mag * HUE_RECIP) >> HUE_RECIP_SHIFT, exact for mag <= 32768.
	localparam logic [15:0] HUE_RECIP       = 16'd46604;
	localparam int unsigned HUE_RECIP_SHIFT = 24;

	// Estimate of floor(p / 15300); it can fall short by one and is corrected later.
	localparam logic [18:0] LEVEL_RECIP       = 19'd280716;
	localparam int unsigned LEVEL_RECIP_SHIFT = 32;

	typedef logic [15:0] mag_t;
	typedef logic [6:0]  hue_quot_t;
	typedef logic [8:0]  hue_t;
	typedef logic [5:0]  rem_t;
	typedef logic [13:0] term_t;
	typedef logic [21:0] prod_t;
	typedef logic [7:0]  byte_t;

	typedef enum logic [2:0] {
		SECTOR_0 = 3'd0,
		SECTOR_1 = 3'd1,
		SECTOR_2 = 3'd2,
		SECTOR_3 = 3'd3,
		SECTOR_4 = 3'd4,
		SECTOR_5 = 3'd5
	} sector_t;

	typedef struct packed {
		sector_t sector;
		rem_t    rem;
		byte_t   sat;
		byte_t   val;
	} hue_split_t;

	typedef struct packed {
		sector_t sector;
		byte_t   val;
	} side_t;

endpackage

### src/hsv_to_rgb_converter_core.sv
// An accepted pixel's colour is offered once the pixel has passed through every pipeline stage.
// Throughput: one pixel per cycle; each stage moves on when its successor is empty or moving.
// A stall at the output backs up only as far as the first empty stage.
// Reset clears the stage valid bits and nothing else; the datapath registers are not reset.
module hsv_to_rgb_converter_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pixel_valid,
	output logic               pixel_ready,
	input  logic signed [15:0] hue_degrees,
	input  logic [7:0]         saturation,
	input  logic [7:0]         brightness,
	output logic               colour_valid,
	input  logic               colour_ready,
	output logic [23:0]        packed_colour
);

	localparam int unsigned DEPTH = hsvrgb_pkg::PIPE_DEPTH;

	logic [DEPTH:1]   stage_valid_q;
	logic [DEPTH+1:1] adv;

	hsvrgb_pkg::hue_split_t split;
	hsvrgb_pkg::rem_t       rise_k;
	hsvrgb_pkg::byte_t      low_lvl, fall_lvl, rise_lvl;
	hsvrgb_pkg::side_t      side_s5, side_s6, side_s7, side_s8, side_s9;
	logic [23:0]            colour_s10;
	logic [23:0]            colour_c;

	// A stage may take new data when it is empty or its content leaves in this cycle.
	always_comb begin
		adv[DEPTH+1] = colour_ready;
		for (int i = DEPTH; i >= 1; i--) begin
			adv[i] = ~stage_valid_q[i] | adv[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (adv[1]) begin
				stage_valid_q[1] <= pixel_valid;
			end
			for (int i = 2; i <= DEPTH; i++) begin
				if (adv[i]) begin
					stage_valid_q[i] <= stage_valid_q[i-1];
				end
			end
		end
	end

	assign pixel_ready = adv[1];

	hsvrgb_hue u_hue (
		.clk         (clk),
		.adv         (adv[4:1]),
		.hue_degrees (hue_degrees),
		.saturation  (saturation),
		.brightness  (brightness),
		.split       (split)
	);

	assign rise_k = hsvrgb_pkg::rem_t'(hsvrgb_pkg::SECTOR_SPAN) - split.rem;

	hsvrgb_level u_low (
		.clk   (clk),
		.adv   (adv[9:5]),
		.k     (hsvrgb_pkg::rem_t'(hsvrgb_pkg::SECTOR_SPAN)),
		.sat   (split.sat),
		.val   (split.val),
		.level (low_lvl)
	);

	hsvrgb_level u_fall (
		.clk   (clk),
		.adv   (adv[9:5]),
		.k     (split.rem),
		.sat   (split.sat),
		.val   (split.val),
		.level (fall_lvl)
	);

	hsvrgb_level u_rise (
		.clk   (clk),
		.adv   (adv[9:5]),
		.k     (rise_k),
		.sat   (split.sat),
		.val   (split.val),
		.level (rise_lvl)
	);

	// Sector and value ride alongside the level lanes.
	always_ff @(posedge clk) begin
		if (adv[5]) begin
			side_s5.sector <= split.sector;
			side_s5.val    <= split.val;
		end
		if (adv[6]) begin
			side_s6 <= side_s5;
		end
		if (adv[7]) begin
			side_s7 <= side_s6;
		end
		if (adv[8]) begin
			side_s8 <= side_s7;
		end
		if (adv[9]) begin
			side_s9 <= side_s8;
		end
	end

	always_comb begin
		case (side_s9.sector)
			hsvrgb_pkg::SECTOR_0: colour_c = {side_s9.val, rise_lvl, low_lvl};
			hsvrgb_pkg::SECTOR_1: colour_c = {fall_lvl, side_s9.val, low_lvl};
			hsvrgb_pkg::SECTOR_2: colour_c = {low_lvl, side_s9.val, rise_lvl};
			hsvrgb_pkg::SECTOR_3: colour_c = {low_lvl, fall_lvl, side_s9.val};
			hsvrgb_pkg::SECTOR_4: colour_c = {rise_lvl, low_lvl, side_s9.val};
			default:              colour_c = {side_s9.val, low_lvl, fall_lvl};
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[DEPTH]) begin
			colour_s10 <= colour_c;
		end
	end

	assign colour_valid  = stage_valid_q[DEPTH];
	assign packed_colour = colour_s10;

endmodule

### src/hsvrgb_hue.sv
// Hue front end: magnitude, modulo 360, and split into sector and remainder (stages 1 to 4).
module hsvrgb_hue (
	input  logic                    clk,
	input  logic [4:1]              adv,
	input  logic signed [15:0]      hue_degrees,
	input  logic [7:0]              saturation,
	input  logic [7:0]              brightness,
	output hsvrgb_pkg::hue_split_t  split
);

	hsvrgb_pkg::mag_t      mag_s1, mag_s2;
	hsvrgb_pkg::byte_t     sat_s1, sat_s2, sat_s3;
	hsvrgb_pkg::byte_t     val_s1, val_s2, val_s3;
	hsvrgb_pkg::hue_quot_t quot_s2;
	hsvrgb_pkg::hue_t      hue_s3;
	hsvrgb_pkg::hue_split_t split_s4;

	logic [31:0]           quot_full;
	logic [22:0]           quot_back;
	hsvrgb_pkg::hue_t      hue_rem;
	hsvrgb_pkg::sector_t   sector_c;
	hsvrgb_pkg::hue_t      sector_base;

	// The most negative hue negates to 0x8000, which reads correctly as 32768 unsigned.
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			mag_s1 <= hue_degrees[15] ? hsvrgb_pkg::mag_t'(~hue_degrees + 16'sd1)
			                          : hsvrgb_pkg::mag_t'(hue_degrees);
			sat_s1 <= saturation;
			val_s1 <= brightness;
		end
	end

	assign quot_full = {16'b0, mag_s1} * {16'b0, hsvrgb_pkg::HUE_RECIP};

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			quot_s2 <= quot_full[hsvrgb_pkg::HUE_RECIP_SHIFT +: 7];
			mag_s2  <= mag_s1;
			sat_s2  <= sat_s1;
			val_s2  <= val_s1;
		end
	end

	assign quot_back = {16'b0, quot_s2} * 23'(hsvrgb_pkg::HUE_FULL);
	assign hue_rem   = 9'({7'b0, mag_s2} - quot_back);

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			hue_s3 <= hue_rem;
			sat_s3 <= sat_s2;
			val_s3 <= val_s2;
		end
	end

	always_comb begin
		if (hue_s3 >= 9'(5 * hsvrgb_pkg::SECTOR_SPAN)) begin
			sector_c    = hsvrgb_pkg::SECTOR_5;
			sector_base = 9'(5 * hsvrgb_pkg::SECTOR_SPAN);
		end else if (hue_s3 >= 9'(4 * hsvrgb_pkg::SECTOR_SPAN)) begin
			sector_c    = hsvrgb_pkg::SECTOR_4;
			sector_base = 9'(4 * hsvrgb_pkg::SECTOR_SPAN);
		end else if (hue_s3 >= 9'(3 * hsvrgb_pkg::SECTOR_SPAN)) begin
			sector_c    = hsvrgb_pkg::SECTOR_3;
			sector_base = 9'(3 * hsvrgb_pkg::SECTOR_SPAN);
		end else if (hue_s3 >= 9'(2 * hsvrgb_pkg::SECTOR_SPAN)) begin
			sector_c    = hsvrgb_pkg::SECTOR_2;
			sector_base = 9'(2 * hsvrgb_pkg::SECTOR_SPAN);
		end else if (hue_s3 >= 9'(hsvrgb_pkg::SECTOR_SPAN)) begin
			sector_c    = hsvrgb_pkg::SECTOR_1;
			sector_base = 9'(hsvrgb_pkg::SECTOR_SPAN);
		end else begin
			sector_c    = hsvrgb_pkg::SECTOR_0;
			sector_base = 9'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			split_s4.sector <= sector_c;
			split_s4.rem    <= hsvrgb_pkg::rem_t'(hue_s3 - sector_base);
			split_s4.sat    <= sat_s3;
			split_s4.val    <= val_s3;
		end
	end

	assign split = split_s4;

endmodule

### src/hsvrgb_level.sv
// One level lane: floor(v * (15300 - k * s) / 15300) over stages 5 to 9.
module hsvrgb_level (
	input  logic              clk,
	input  logic [9:5]        adv,
	input  hsvrgb_pkg::rem_t  k,
	input  hsvrgb_pkg::byte_t sat,
	input  hsvrgb_pkg::byte_t val,
	output hsvrgb_pkg::byte_t level
);

	hsvrgb_pkg::term_t term_s5;
	hsvrgb_pkg::byte_t val_s5;
	hsvrgb_pkg::prod_t prod_s6, prod_s7, prod_s8, back_s8;
	hsvrgb_pkg::byte_t quot_s7, quot_s8, level_s9;

	hsvrgb_pkg::term_t ks;
	hsvrgb_pkg::prod_t prod_c, back_c, resid;
	logic [40:0]       est_full;

	assign ks = {8'b0, k} * {6'b0, sat};

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			term_s5 <= 14'(hsvrgb_pkg::LEVEL_DENOM) - ks;
			val_s5  <= val;
		end
	end

	assign prod_c = {14'b0, val_s5} * {8'b0, term_s5};

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			prod_s6 <= prod_c;
		end
	end

	assign est_full = {19'b0, prod_s6} * {22'b0, hsvrgb_pkg::LEVEL_RECIP};

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			quot_s7 <= est_full[hsvrgb_pkg::LEVEL_RECIP_SHIFT +: 8];
			prod_s7 <= prod_s6;
		end
	end

	assign back_c = {14'b0, quot_s7} * 22'(hsvrgb_pkg::LEVEL_DENOM);

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			back_s8 <= back_c;
			quot_s8 <= quot_s7;
			prod_s8 <= prod_s7;
		end
	end

	// The estimate is never high and at most one short, so one step fixes it.
	assign resid = prod_s8 - back_s8;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			level_s9 <= (resid >= 22'(hsvrgb_pkg::LEVEL_DENOM)) ? quot_s8 + 8'd1 : quot_s8;
		end
	end

	assign level = level_s9;

endmodule

### src/hsvrgb_checker.sv
// Port-level checks for the HSV to RGB converter, bound to the top level.
module hsvrgb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pixel_valid,
	input logic        pixel_ready,
	input logic        colour_valid,
	input logic        colour_ready,
	input logic [23:0] packed_colour
);

	// With the output draining, every stage moves, so the input must be open.
	a_ready_when_draining: assert property (@(posedge clk) disable iff (!arst_n)
		colour_ready |-> pixel_ready)
		else $error("pixel_ready low while colour_ready high");

	// No result may be offered in the cycle right after reset.
	a_empty_after_reset: assert property (@(posedge clk)
		!$past(arst_n) |-> !colour_valid)
		else $error("colour_valid high right after reset");

	// A stalled result stays offered.
	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		colour_valid && !colour_ready |=> colour_valid)
		else $error("colour dropped while stalled");

	// A stalled result keeps its value.
	a_colour_held: assert property (@(posedge clk) disable iff (!arst_n)
		colour_valid && !colour_ready |=> $stable(packed_colour))
		else $error("packed_colour changed while stalled");

	// A pixel that is not taken stays offered.
	a_pixel_held: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_ready |=> pixel_valid)
		else $error("pixel_valid dropped before its transfer");

endmodule

bind hsv_to_rgb_converter_core hsvrgb_checker u_hsvrgb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.pixel_valid   (pixel_valid),
	.pixel_ready   (pixel_ready),
	.colour_valid  (colour_valid),
	.colour_ready  (colour_ready),
	.packed_colour (packed_colour)
);

### tb/sv/testbench.sv
// Self-checking testbench for the HSV to RGB converter core.
module testbench;

	localparam int unsigned CYCLE_LIMIT = 200000;

	logic               clk;
	logic               arst_n;
	logic               pixel_valid;
	logic               pixel_ready;
	logic signed [15:0] hue_degrees;
	logic [7:0]         saturation;
	logic [7:0]         brightness;
	logic               colour_valid;
	logic               colour_ready;
	logic [23:0]        packed_colour;

	logic [23:0] expected_colours[$];
	logic [23:0] oldest_colour;
	int          sender_idle_pct;
	int          recv_stall_pct;
	int          pixels_sent;
	int          colours_checked;
	int          error_count;

	hsv_to_rgb_converter_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.hue_degrees  (hue_degrees),
		.saturation   (saturation),
		.brightness   (brightness),
		.colour_valid (colour_valid),
		.colour_ready (colour_ready),
		.packed_colour(packed_colour)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Expected colour for one pixel, computed in plain integer arithmetic.
	function automatic logic [23:0] predict_colour(input logic signed [15:0] hue,
			input hsvrgb_pkg::byte_t sat, input hsvrgb_pkg::byte_t val);
		int unsigned         magnitude;
		int unsigned         wrapped;
		int unsigned         rem;
		int unsigned         low_lvl;
		int unsigned         fall_lvl;
		int unsigned         rise_lvl;
		int unsigned         v;
		int unsigned         s;
		hsvrgb_pkg::byte_t   red;
		hsvrgb_pkg::byte_t   green;
		hsvrgb_pkg::byte_t   blue;
		hsvrgb_pkg::sector_t sector;
		magnitude = (hue < 0) ? int'(-int'(hue)) : int'(hue);
		wrapped   = magnitude % hsvrgb_pkg::HUE_FULL;
		sector    = hsvrgb_pkg::sector_t'(wrapped / hsvrgb_pkg::SECTOR_SPAN);
		rem       = wrapped % hsvrgb_pkg::SECTOR_SPAN;
		v         = val;
		s         = sat;
		low_lvl   = (v * (hsvrgb_pkg::UNIT_MAX - s) * hsvrgb_pkg::SECTOR_SPAN)
			/ hsvrgb_pkg::LEVEL_DENOM;
		fall_lvl  = (v * (hsvrgb_pkg::LEVEL_DENOM - rem * s)) / hsvrgb_pkg::LEVEL_DENOM;
		rise_lvl  = (v * (hsvrgb_pkg::LEVEL_DENOM - (hsvrgb_pkg::SECTOR_SPAN - rem) * s))
			/ hsvrgb_pkg::LEVEL_DENOM;
		case (sector)
			hsvrgb_pkg::SECTOR_0: begin
				red   = val;
				green = hsvrgb_pkg::byte_t'(rise_lvl);
				blue  = hsvrgb_pkg::byte_t'(low_lvl);
			end
			hsvrgb_pkg::SECTOR_1: begin
				red   = hsvrgb_pkg::byte_t'(fall_lvl);
				green = val;
				blue  = hsvrgb_pkg::byte_t'(low_lvl);
			end
			hsvrgb_pkg::SECTOR_2: begin
				red   = hsvrgb_pkg::byte_t'(low_lvl);
				green = val;
				blue  = hsvrgb_pkg::byte_t'(rise_lvl);
			end
			hsvrgb_pkg::SECTOR_3: begin
				red   = hsvrgb_pkg::byte_t'(low_lvl);
				green = hsvrgb_pkg::byte_t'(fall_lvl);
				blue  = val;
			end
			hsvrgb_pkg::SECTOR_4: begin
				red   = hsvrgb_pkg::byte_t'(rise_lvl);
				green = hsvrgb_pkg::byte_t'(low_lvl);
				blue  = val;
			end
			default: begin
				red   = val;
				green = hsvrgb_pkg::byte_t'(low_lvl);
				blue  = hsvrgb_pkg::byte_t'(fall_lvl);
			end
		endcase
		return {red, green, blue};
	endfunction

	task automatic report_failure(input string what);
		error_count++;
		$display("ERROR at %0t: %s", $time, what);
	endtask

	// Offers one pixel, idling first as the current phase asks, and waits for its transfer.
	task automatic send_pixel(input logic signed [15:0] hue, input hsvrgb_pkg::byte_t sat,
			input hsvrgb_pkg::byte_t val);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			pixel_valid <= 1'b0;
			@(negedge clk);
		end
		pixel_valid <= 1'b1;
		hue_degrees <= hue;
		saturation  <= sat;
		brightness  <= val;
		do @(posedge clk); while (pixel_ready !== 1'b1);
		expected_colours.push_back(predict_colour(hue, sat, val));
		pixels_sent++;
	endtask

	task automatic lower_valid();
		@(negedge clk);
		pixel_valid <= 1'b0;
	endtask

	function automatic logic signed [15:0] pick_hue();
		int k;
		case ($urandom_range(4))
			0: return 16'($urandom);
			1: return 16'(int'($urandom_range(1440)) - 720);
			2: begin
				k = int'($urandom_range(90)) * hsvrgb_pkg::HUE_FULL
					+ int'($urandom_range(2)) - 1;
				return ($urandom_range(1) != 0) ? 16'(-k) : 16'(k);
			end
			3: begin
				k = int'($urandom_range(545)) * hsvrgb_pkg::SECTOR_SPAN
					+ (($urandom_range(1) != 0) ? hsvrgb_pkg::SECTOR_SPAN - 1 : 0);
				return ($urandom_range(1) != 0) ? 16'(-k) : 16'(k);
			end
			default: return ($urandom_range(1) != 0) ? 16'(-32768 + int'($urandom_range(15)))
				: 16'(32767 - int'($urandom_range(15)));
		endcase
	endfunction

	function automatic hsvrgb_pkg::byte_t pick_level();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			default: return hsvrgb_pkg::byte_t'($urandom);
		endcase
	endfunction

	task automatic test_hue_extremes();
		send_pixel(-16'sd32768, 8'd255, 8'd255);
		send_pixel(16'sd32767, 8'd255, 8'd255);
		send_pixel(16'sd0, 8'd255, 8'd255);
		send_pixel(16'sd360, 8'd200, 8'd180);
		send_pixel(-16'sd360, 8'd200, 8'd180);
		send_pixel(16'sd32760, 8'd128, 8'd255);
		send_pixel(-16'sd1, 8'd255, 8'd255);
	endtask

	// Both ends of every 60-degree sector, plus one negative hue.
	task automatic test_sector_edges();
		for (int k = 0; k < 6; k++) begin
			send_pixel(16'(k * hsvrgb_pkg::SECTOR_SPAN), 8'd255, 8'd255);
			send_pixel(16'(k * hsvrgb_pkg::SECTOR_SPAN + hsvrgb_pkg::SECTOR_SPAN - 1),
				8'd170, 8'd200);
		end
		send_pixel(-16'sd300, 8'd90, 8'd77);
	endtask

	task automatic test_level_extremes();
		send_pixel(16'sd30, 8'd0, 8'd255);
		send_pixel(16'sd30, 8'd255, 8'd0);
		send_pixel(16'sd30, 8'd0, 8'd0);
		send_pixel(16'sd200, 8'd255, 8'd255);
	endtask

	task automatic test_random_traffic(input int count, input int send_idle,
			input int recv_stall);
		sender_idle_pct = send_idle;
		recv_stall_pct  = recv_stall;
		repeat (count) send_pixel(pick_hue(), pick_level(), pick_level());
	endtask

	// The sender holds off until the pipeline has delivered every pending colour.
	task automatic test_pause_until_drained();
		sender_idle_pct = 30;
		recv_stall_pct  = 30;
		repeat (20) send_pixel(pick_hue(), pick_level(), pick_level());
		lower_valid();
		while (expected_colours.size() != 0) @(posedge clk);
		repeat (20) send_pixel(pick_hue(), pick_level(), pick_level());
	endtask

	// Receiver: ready is redrawn every cycle from the current stall rate.
	initial begin
		colour_ready = 1'b0;
		forever begin
			@(negedge clk);
			colour_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Checks each colour transfer against the oldest pending prediction.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && colour_valid === 1'b1 && colour_ready === 1'b1) begin
				if (expected_colours.size() == 0) begin
					report_failure($sformatf("colour %06h with no pixel pending",
						packed_colour));
				end else begin
					oldest_colour = expected_colours.pop_front();
					colours_checked++;
					if (packed_colour !== oldest_colour)
						report_failure($sformatf("colour %06h, predicted %06h",
							packed_colour, oldest_colour));
				end
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Timeout after %0d cycles", CYCLE_LIMIT);
		$display("Verification failed");
		$finish;
	end

	initial begin
		arst_n          = 1'b0;
		pixel_valid     = 1'b0;
		hue_degrees     = '0;
		saturation      = '0;
		brightness      = '0;
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		pixels_sent     = 0;
		colours_checked = 0;
		error_count     = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_hue_extremes();
		test_sector_edges();
		test_level_extremes();
		test_random_traffic(350, 0, 0);
		test_random_traffic(350, 87, 0);
		test_random_traffic(350, 0, 87);
		test_pause_until_drained();
		test_random_traffic(350, 30, 30);
		test_random_traffic(300, 0, 0);

		lower_valid();
		recv_stall_pct = 0;
		while (expected_colours.size() != 0) @(posedge clk);
		repeat (hsvrgb_pkg::PIPE_DEPTH * 2) @(posedge clk);

		$display("Sent %0d pixels and checked %0d colours across all sectors and hue extremes,",
			pixels_sent, colours_checked);
		$display("with sender gaps, receiver stalls and a full drain pause; %0d errors.",
			error_count);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### filelist.f
src/hsvrgb_pkg.sv
src/hsvrgb_hue.sv
src/hsvrgb_level.sv
src/hsv_to_rgb_converter_core.sv
src/hsvrgb_checker.sv
tb/sv/testbench.sv
